// ----- rtl/osv_pkg.sv -----
// package for the octant shadowcast visibility block: sizes, slope tables, shared types
package osv_pkg;

  localparam int RADIUS = 8;
  localparam int SLOTS  = 6;

  localparam int COORD_W    = 3;
  localparam int SLOPE_W    = 17;
  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DIST_W     = 2 * COORD_W + 2;
  localparam int RSQ_W      = DIST_W + 1;

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [SLOPE_W-1:0]    slope_t;
  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  localparam logic [RSQ_W-1:0] RADIUS_SQ = RSQ_W'(RADIUS * RADIUS);
  localparam slot_idx_t IDX_LAST = SLOT_IDX_W'(SLOTS - 1);

  // left slope col/(row+2), indexed by {row, col}, saturated
  localparam slope_t LEFT_TAB [0:63] = '{
    17'd0, 17'd32768, 17'd65536, 17'd98304, 17'd131071, 17'd131071, 17'd131071, 17'd131071,
    17'd0, 17'd21845, 17'd43690, 17'd65536, 17'd87381, 17'd109226, 17'd131071, 17'd131071,
    17'd0, 17'd16384, 17'd32768, 17'd49152, 17'd65536, 17'd81920, 17'd98304, 17'd114688,
    17'd0, 17'd13107, 17'd26214, 17'd39321, 17'd52428, 17'd65536, 17'd78643, 17'd91750,
    17'd0, 17'd10922, 17'd21845, 17'd32768, 17'd43690, 17'd54613, 17'd65536, 17'd76458,
    17'd0, 17'd9362, 17'd18724, 17'd28086, 17'd37449, 17'd46811, 17'd56173, 17'd65536,
    17'd0, 17'd8192, 17'd16384, 17'd24576, 17'd32768, 17'd40960, 17'd49152, 17'd57344,
    17'd0, 17'd7281, 17'd14563, 17'd21845, 17'd29127, 17'd36408, 17'd43690, 17'd50972
  };

  // right slope (col+1)/(row+1), indexed by {row, col}, saturated
  localparam slope_t RIGHT_TAB [0:63] = '{
    17'd65536, 17'd131071, 17'd131071, 17'd131071,
    17'd131071, 17'd131071, 17'd131071, 17'd131071,
    17'd32768, 17'd65536, 17'd98304, 17'd131071,
    17'd131071, 17'd131071, 17'd131071, 17'd131071,
    17'd21845, 17'd43690, 17'd65536, 17'd87381,
    17'd109226, 17'd131071, 17'd131071, 17'd131071,
    17'd16384, 17'd32768, 17'd49152, 17'd65536,
    17'd81920, 17'd98304, 17'd114688, 17'd131071,
    17'd13107, 17'd26214, 17'd39321, 17'd52428,
    17'd65536, 17'd78643, 17'd91750, 17'd104857,
    17'd10922, 17'd21845, 17'd32768, 17'd43690,
    17'd54613, 17'd65536, 17'd76458, 17'd87381,
    17'd9362, 17'd18724, 17'd28086, 17'd37449,
    17'd46811, 17'd56173, 17'd65536, 17'd74898,
    17'd8192, 17'd16384, 17'd24576, 17'd32768,
    17'd40960, 17'd49152, 17'd57344, 17'd65536
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } osv_state_t;

  typedef struct packed {
    logic      load;
    logic      step;
    logic      finish;
    slot_idx_t idx;
  } osv_cmd_t;

  typedef struct packed {
    logic in_radius;
    logic hit;
    logic out_busy;
  } osv_sts_t;

endpackage

// ----- rtl/octant_shadowcast_visibility_top.sv -----
// top level of the octant shadowcast visibility block
//
//  channel | dir | handshake          | tdata (low bit up)                 | tuser
//  s_      | in  | s_tvalid/s_tready  | row[2:0] col[5:3] solid[6] pad[7]  | first_of_octant
//  m_      | out | m_tvalid/m_tready  | row[2:0] col[5:3] visible[6] pad[7]| -
//
// a cell inside the radius is accepted, scanned against each shadow slot in turn by the scan
// sequencer, then inserted and loaded into the output register; a covered cell ends
// its scan at the covering slot. a cell outside the radius is accepted and gives no word.
// rst is synchronous and clears all shadow slots and the output valid.
// the next cell is taken while a result word waits; a cell stalls only at insert when the
// output register still holds an untaken word.
module octant_shadowcast_visibility_top
  import osv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // row[2:0], col[5:3], solid[6], zero[7]
  input  logic       s_tuser,   // first_of_octant
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // out_row[2:0], out_col[5:3], visible[6], zero[7]
);

  osv_cmd_t cmd;
  osv_sts_t sts;

  osv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  osv_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ----- rtl/osv_ctrl.sv -----
// controller state machine: accept, slot scan sequencing and result hand-off
module osv_ctrl
  import osv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  osv_sts_t sts,
  output osv_cmd_t cmd
);

  osv_state_t state, state_next;
  slot_idx_t  idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_radius) begin
            state_next = ST_SCAN;
            idx_next   = '0;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.hit || idx == IDX_LAST) begin
          state_next = ST_FINISH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy)
    else $error("result issued while output word still pending");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= IDX_LAST))
    else $error("scan index beyond last slot");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && sts.in_radius) |=> (state == ST_SCAN && idx == '0))
    else $error("cell inside radius did not start a scan");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (cmd.load == 1'b0 || $past(sts.hit) || $past(idx) == IDX_LAST))
    else $error("word accepted during slot scan");
`endif

endmodule

// ----- rtl/osv_datapath.sv -----
// datapath: slope lookup, shadow slot store, cover and merge tests, result register
module osv_datapath
  import osv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  input  osv_cmd_t   cmd,
  output osv_sts_t   sts
);

  coord_t row_in, col_in;
  logic   solid_in;
  logic [DIST_W-1:0] dist_sq;
  logic [5:0] tab_idx;

  coord_t row, col;
  logic   solid, vis;
  slope_t left, right;

  logic   used [SLOTS];
  slope_t slot_left [SLOTS];
  slope_t slot_right [SLOTS];

  slope_t    cur_l, cur_r;
  logic      cur_used, hit, merge_l, merge_r;
  logic      free_found;
  slot_idx_t free_idx;

  coord_t out_row, out_col;
  logic   out_vis;

  assign row_in   = s_tdata[2:0];
  assign col_in   = s_tdata[5:3];
  assign solid_in = s_tdata[6];
  assign tab_idx  = {row_in, col_in};

  assign dist_sq = DIST_W'({{(DIST_W-COORD_W){1'b0}}, row_in} * {{(DIST_W-COORD_W){1'b0}}, row_in})
                 + DIST_W'({{(DIST_W-COORD_W){1'b0}}, col_in} * {{(DIST_W-COORD_W){1'b0}}, col_in});

  assign cur_used = used[cmd.idx];
  assign cur_l    = slot_left[cmd.idx];
  assign cur_r    = slot_right[cmd.idx];

  assign hit     = cur_used && (left >= cur_l) && (right <= cur_r);
  assign merge_l = cur_used && !hit && solid && (left >= cur_l) && (left < cur_r);
  assign merge_r = cur_used && !hit && solid && (right > cur_l) && (right <= cur_r);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  assign sts.in_radius = ({1'b0, dist_sq} < RADIUS_SQ);
  assign sts.hit       = hit;
  assign sts.out_busy  = m_tvalid && !m_tready;

  // slot valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) used[i] <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load && s_tuser) begin
        for (int i = 0; i < SLOTS; i++) used[i] <= 1'b0;
      end
      if (cmd.step && (merge_l || merge_r)) begin
        used[cmd.idx] <= 1'b0;
      end
      if (cmd.finish && vis && solid && free_found) begin
        used[free_idx] <= 1'b1;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // working cell, slot payload and output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row   <= row_in;
      col   <= col_in;
      solid <= solid_in;
      vis   <= 1'b1;
      left  <= LEFT_TAB[tab_idx];
      right <= RIGHT_TAB[tab_idx];
    end else if (cmd.step) begin
      if (hit) vis <= 1'b0;
      if (merge_l) left <= cur_l;
      if (merge_r) right <= cur_r;
    end
    if (cmd.finish && vis && solid && free_found) begin
      slot_left[free_idx]  <= left;
      slot_right[free_idx] <= right;
    end
    if (cmd.finish) begin
      out_row <= row;
      out_col <= col;
      out_vis <= vis;
    end
  end

  assign m_tdata = {1'b0, out_vis, out_col, out_row};

endmodule

// ----- tb/tb_octant_shadowcast_visibility_top.sv -----
// self-checking testbench for the octant shadowcast visibility block: directed and random cells
module tb_octant_shadowcast_visibility_top;
  import osv_pkg::*;

  localparam int SLOPE_CAP   = (1 << SLOPE_W) - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4 * (SLOTS + 2);

  typedef struct {
    coord_t row;
    coord_t col;
    logic   lit;
  } cell_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  logic   shadow_used [SLOTS] = '{default: 1'b0};
  slope_t shadow_lo   [SLOTS] = '{default: '0};
  slope_t shadow_hi   [SLOTS] = '{default: '0};

  cell_word_t lit_expect [$];

  int   errors = 0;
  int   cycles = 0;
  int   cells_in_radius = 0;
  int   cells_outside = 0;
  int   cells_hidden = 0;
  int   spans_dropped = 0;
  int   words_checked = 0;
  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;

  octant_shadowcast_visibility_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, lit_expect.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic slope_t slope_of(input int num, input int den);
    int q;
    q = (num * 65536) / den;
    if (q > SLOPE_CAP) q = SLOPE_CAP;
    return slope_t'(q);
  endfunction

  function automatic void predict_cell(input logic first, input coord_t row, input coord_t col,
                                       input logic solid);
    int     range_sq;
    slope_t lo;
    slope_t hi;
    logic   lit;
    logic   placed;
    int     i;
    if (first) shadow_used = '{default: 1'b0};
    range_sq = int'(row) * int'(row) + int'(col) * int'(col);
    if (range_sq >= RADIUS * RADIUS) begin
      cells_outside++;
      return;
    end
    cells_in_radius++;
    lo = slope_of(int'(col), int'(row) + 2);
    hi = slope_of(int'(col) + 1, int'(row) + 1);
    lit = 1'b1;
    for (i = 0; i < SLOTS; i++) begin
      if (!shadow_used[i]) continue;
      if (lo >= shadow_lo[i] && hi <= shadow_hi[i]) begin
        lit = 1'b0;
        break;
      end
      if (solid) begin
        // left edge first; the right test uses only the right edge
        if (lo >= shadow_lo[i] && lo < shadow_hi[i]) begin
          lo = shadow_lo[i];
          shadow_used[i] = 1'b0;
        end
        if (hi > shadow_lo[i] && hi <= shadow_hi[i]) begin
          hi = shadow_hi[i];
          shadow_used[i] = 1'b0;
        end
      end
    end
    if (lit && solid) begin
      placed = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
        if (!shadow_used[i]) begin
          shadow_lo[i] = lo;
          shadow_hi[i] = hi;
          shadow_used[i] = 1'b1;
          placed = 1'b1;
          break;
        end
      end
      if (!placed) spans_dropped++;
    end
    if (!lit) cells_hidden++;
    lit_expect.push_back('{row, col, lit});
  endfunction

  task automatic report_mismatch(input string what, input int got, input int wanted);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d wanted %0d", cycles, what, got, wanted);
  endtask

  always @(posedge clk) begin
    cell_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lit_expect.size() == 0) begin
        report_mismatch("unexpected word, tdata", int'(m_tdata), 0);
      end else begin
        want = lit_expect.pop_front();
        words_checked++;
        if (m_tdata[2:0] !== want.row) begin
          report_mismatch("out_row", int'(m_tdata[2:0]), int'(want.row));
        end
        if (m_tdata[5:3] !== want.col) begin
          report_mismatch("out_col", int'(m_tdata[5:3]), int'(want.col));
        end
        if (m_tdata[6] !== want.lit) begin
          report_mismatch("visible", int'(m_tdata[6]), int'(want.lit));
        end
        if (m_tdata[7] !== 1'b0) report_mismatch("pad bit", int'(m_tdata[7]), 0);
      end
    end
  end

  // receiver: short random stalls, or one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_cell(input logic first, input coord_t row, input coord_t col,
                           input logic solid);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, solid, col, row};
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    predict_cell(first, row, col, solid);
  endtask

  task automatic release_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (lit_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one octant in scan order; a missing first flag leaves stale shadows in place
  task automatic run_scan(input int max_row, input int density, input logic clear);
    int r;
    int c;
    for (r = 0; r <= max_row; r++) begin
      for (c = 0; c <= r; c++) begin
        send_cell(clear && r == 0 && c == 0, coord_t'(r), coord_t'(c),
                  $urandom_range(0, 99) < density);
      end
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) begin
      send_cell($urandom_range(0, 7) == 0, coord_t'($urandom_range(0, 7)),
                coord_t'($urandom_range(0, 7)), $urandom_range(0, 1) == 1);
    end
  endtask

  task automatic run_mixed(input int target);
    int stop_at;
    stop_at = cells_in_radius + target;
    while (cells_in_radius < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        run_scan($urandom_range(1, 7), $urandom_range(5, 70), $urandom_range(0, 9) != 0);
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end
  endtask

  task automatic test_directed();
    send_cell(1'b1, 3'd0, 3'd0, 1'b0);
    send_cell(1'b0, 3'd7, 3'd7, 1'b1);
    send_cell(1'b0, 3'd7, 3'd0, 1'b0);
    send_cell(1'b0, 3'd0, 3'd7, 1'b1);
    send_cell(1'b1, 3'd1, 3'd0, 1'b1);
    send_cell(1'b0, 3'd2, 3'd1, 1'b1);
    send_cell(1'b0, 3'd3, 3'd1, 1'b0);
    send_cell(1'b0, 3'd2, 3'd0, 1'b1);
    send_cell(1'b1, 3'd7, 3'd7, 1'b0);
    send_cell(1'b0, 3'd3, 3'd1, 1'b0);
    // six disjoint shadows, then intervals with nowhere to go
    send_cell(1'b1, 3'd7, 3'd0, 1'b1);
    send_cell(1'b0, 3'd6, 3'd1, 1'b1);
    send_cell(1'b0, 3'd7, 3'd3, 1'b1);
    send_cell(1'b0, 3'd5, 3'd4, 1'b1);
    send_cell(1'b0, 3'd4, 3'd5, 1'b1);
    send_cell(1'b0, 3'd3, 3'd6, 1'b1);
    send_cell(1'b0, 3'd1, 3'd7, 1'b1);
    send_cell(1'b0, 3'd1, 3'd7, 1'b1);
    send_cell(1'b0, 3'd7, 3'd2, 1'b0);
    send_cell(1'b0, 3'd6, 3'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random();
    run_mixed(1350);
    wait_drained();
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_req = 1'b1;
    run_scan(7, 50, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    run_mixed(350);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();
    $display("cells in radius %0d, outside %0d, hidden %0d, words checked %0d",
             cells_in_radius, cells_outside, cells_hidden, words_checked);
    $display("shadow intervals dropped for want of a slot: %0d, mismatches %0d",
             spans_dropped, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
